@@ rtl/core/fpa_pkg.sv @@
// Package for the signed fixed-point ALU: operation codes and the pipeline token type.
// It has no dependencies. Every module imports it; the interface file does not.
`default_nettype none
package fpa_pkg;
    localparam int OP_W = 32;
    localparam int FRAC = 8;
    localparam int MAG_W = 32;
    localparam int NUM_W = MAG_W + FRAC + 1;
    localparam int DIV_STEPS = NUM_W;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MIN  = 4'd4,
        OP_MAX  = 4'd5,
        OP_INC  = 4'd6,
        OP_DEC  = 4'd7,
        OP_INT  = 4'd8,
        OP_FIX  = 4'd9
    } op_t;

    // State carried down the chain of divider cells.
    typedef struct packed {
        logic              valid;
        logic [3:0]        kind;
        logic [OP_W-1:0]   res;
        logic              sat;
        logic              dz;
        logic              lt;
        logic              eq;
        logic              gt;
        logic              neg;
        logic              is_div;
        logic [NUM_W-1:0]  num;
        logic [MAG_W:0]    rem;
        logic [NUM_W-1:0]  quo;
        logic [MAG_W-1:0]  den;
    } tok_t;
endpackage
`default_nettype wire

@@ rtl/core/fpa_if.sv @@
// Valid/ready channel interface carrying the operands or a result.
// Depends on nothing; the payload width is a parameter.
`default_nettype none
interface fpa_if #(parameter int W = 68);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/fpa_front.sv @@
// Front stage: decodes the operation, does every operation but the divide, including the
// multiply, and sets up the divider numerator. Depends on fpa_pkg.
`default_nettype none
module fpa_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [3:0]     kind,
    input  wire logic [31:0]    operand_a,
    input  wire logic [31:0]    operand_b,
    output fpa_pkg::tok_t       tok
);
    import fpa_pkg::*;

    logic signed [32:0] a_ext;
    logic signed [32:0] b_ext;
    logic signed [33:0] sum_w;
    logic signed [33:0] dif_w;
    logic signed [33:0] inc_w;
    logic signed [33:0] dec_w;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [63:0] prod;
    logic [63:0] prod_r;
    logic        neg;
    tok_t        t_next;
    tok_t        tok_reg;
    logic signed [OP_W-1:0] max_v;
    logic signed [OP_W-1:0] min_v;

    // Clamp a wide signed value to the word.
    function automatic logic [32:0] clamp34(input logic signed [33:0] v);
        logic [32:0] r;
        if (v > 34'sh07FFFFFFF)
            r = {1'b1, 32'h7FFFFFFF};
        else if (v < -34'sh080000000)
            r = {1'b1, 32'h80000000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

    always_comb
    begin
        max_v = 32'sh7FFFFFFF;
        min_v = 32'sh80000000;
        a_ext = {operand_a[31], operand_a};
        b_ext = {operand_b[31], operand_b};
        sum_w = 34'(a_ext) + 34'(b_ext);
        dif_w = 34'(a_ext) - 34'(b_ext);
        inc_w = 34'(a_ext) + 34'sd1;
        dec_w = 34'(a_ext) - 34'sd1;
        mag_a = operand_a[31] ? 32'(-a_ext) : operand_a;
        mag_b = operand_b[31] ? 32'(-b_ext) : operand_b;
        prod  = 64'(mag_a) * 64'(mag_b);
        neg   = operand_a[31] ^ operand_b[31];
    end

    // Decode and the results of the simple operations.
    always_comb
    begin
        logic [32:0] c;
        c = '0;
        t_next = '0;
        t_next.valid = in_valid;
        t_next.kind  = kind;
        t_next.lt    = a_ext < b_ext;
        t_next.eq    = a_ext == b_ext;
        t_next.gt    = a_ext > b_ext;
        t_next.neg   = neg;
        t_next.den   = mag_b;
        t_next.num   = NUM_W'({mag_a, {FRAC{1'b0}}, 1'b0}) + NUM_W'(mag_b);
        case (kind)
            OP_ADD: c = clamp34(sum_w);
            OP_SUB: c = clamp34(dif_w);
            OP_INC: c = clamp34(inc_w);
            OP_DEC: c = clamp34(dec_w);
            OP_MIN: c = {1'b0, (a_ext <= b_ext) ? operand_a : operand_b};
            OP_MAX: c = {1'b0, (a_ext > b_ext) ? operand_a : operand_b};
            OP_INT: c = {1'b0, 32'($signed(operand_a) >>> FRAC)};
            OP_FIX:
            begin
                if (operand_a[31:23] != 9'h000 && operand_a[31:23] != 9'h1FF)
                    c = {1'b1, operand_a[31] ? min_v : max_v};
                else
                    c = {1'b0, operand_a[23:0], 8'h00};
            end
            OP_DIV:
            begin
                if (mag_b == '0)
                begin
                    t_next.dz = 1'b1;
                    if (operand_a[31])
                        c = {1'b1, min_v};
                    else if (operand_a != '0)
                        c = {1'b1, max_v};
                end
                else
                    t_next.is_div = 1'b1;
            end
            default: c = '0;
        endcase
        t_next.res = c[31:0];
        t_next.sat = c[32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else if (en)
            tok_reg <= t_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prod_r <= prod;
    end

    // Second half of multiply: round and clamp after the product register.
    always_comb
    begin
        logic [56:0] q;
        q = 57'((prod_r + 64'd128) >> FRAC);
        tok = tok_reg;
        if (tok_reg.kind == OP_MUL)
        begin
            if (!tok_reg.neg && q > 57'h07FFFFFFF)
                {tok.sat, tok.res} = {1'b1, 32'h7FFFFFFF};
            else if (tok_reg.neg && q > 57'h080000000)
                {tok.sat, tok.res} = {1'b1, 32'h80000000};
            else
                {tok.sat, tok.res} = {1'b0, tok_reg.neg ? 32'(-q) : q[31:0]};
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/fpa_cell.sv @@
// One cell of the divider chain: a restoring step on the rounded-quotient
// division, one quotient bit per cell. Depends on fpa_pkg.
`default_nettype none
module fpa_cell (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  fpa_pkg::tok_t  tin,
    output fpa_pkg::tok_t  tout
);
    import fpa_pkg::*;

    tok_t           t_next;
    tok_t           t_reg;
    logic [MAG_W+1:0] trial;

    // Shift in the next numerator bit and try to subtract twice the divisor.
    always_comb
    begin
        t_next = tin;
        trial  = {tin.rem, tin.num[NUM_W-1]} - {1'b0, tin.den, 1'b0};
        t_next.num = {tin.num[NUM_W-2:0], 1'b0};
        if (!trial[MAG_W+1])
        begin
            t_next.rem = trial[MAG_W:0];
            t_next.quo = {tin.quo[NUM_W-2:0], 1'b1};
        end
        else
        begin
            t_next.rem = {tin.rem[MAG_W-1:0], tin.num[NUM_W-1]};
            t_next.quo = {tin.quo[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_reg <= '0;
        else if (en)
            t_reg <= t_next;
    end

    assign tout = t_reg;
endmodule
`default_nettype wire

@@ rtl/core/fixed_point_q24_8_alu_top.sv @@
// Top level of the Q24.8 fixed-point ALU: front stage, divider cell chain, output.
// Depends on fpa_pkg, fpa_if, fpa_front and fpa_cell.
//
// Usage: operations enter on channel in (data = {kind, operand_a, operand_b}),
// results leave on channel out (data = {result, a_less, a_equal, a_greater,
// saturated, divide_by_zero}). One transfer each per item, in order.
// Every kind passes through the same registers from input transfer to output valid:
// one front register (the product register sits beside it in the same stage),
// 41 divider cells (one quotient bit each) and the output register.
// The pipeline takes one item per cycle while the receiver does not stall.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, the pipe holds and in.ready falls, so nothing is lost.
// Reset clears the pipeline tokens and the output valid; the product and
// output data registers are left as they are.
`default_nettype none
module fixed_point_q24_8_alu_top (
    input wire logic clk,
    input wire logic rst_n,
    fpa_if.sink      in,
    fpa_if.source    out
);
    import fpa_pkg::*;

    tok_t chain [DIV_STEPS+1];
    logic en;
    logic out_valid_reg;
    logic [36:0] out_data_reg;
    logic [NUM_W-1:0] q;
    logic [36:0] fin;

    // Advance when the output register is empty or being drained.
    assign en = !out_valid_reg || out.ready;
    assign in.ready = en;

    fpa_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in.valid),
        .kind(in.data[67:64]), .operand_a(in.data[63:32]),
        .operand_b(in.data[31:0]), .tok(chain[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        fpa_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en), .tin(chain[i]), .tout(chain[i+1])
        );
    end

    // Apply sign and clamp to the divider quotient.
    always_comb
    begin
        tok_t t;
        t = chain[DIV_STEPS];
        q = t.quo;
        fin = {t.res, t.lt, t.eq, t.gt, t.sat, t.dz};
        if (t.is_div)
        begin
            if (!t.neg && q > NUM_W'(32'h7FFFFFFF))
                fin = {32'h7FFFFFFF, t.lt, t.eq, t.gt, 1'b1, 1'b0};
            else if (t.neg && q > NUM_W'(32'h80000000))
                fin = {32'h80000000, t.lt, t.eq, t.gt, 1'b1, 1'b0};
            else
                fin = {t.neg ? 32'(-q) : q[31:0], t.lt, t.eq, t.gt, 1'b0, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= chain[DIV_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= fin;
    end

    assign out.valid = out_valid_reg;
    assign out.data  = out_data_reg;
endmodule
`default_nettype wire

@@ dv/fpa_checker.sv @@
// Result checker for the Q24.8 fixed-point ALU: watches both channels, predicts and compares.
// Depends on fpa_pkg and fpa_if.
`default_nettype none
module fpa_checker
    import fpa_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    fpa_if           in,
    fpa_if           out,
    output int       fail_count,
    output int       pending_count,
    output int       result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] result;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        sat;
        logic        dz;
    } alu_res_t;

    alu_res_t expected_results[$];

    // Clamp a wide value to the word range, noting any clamping.
    function automatic longint clamp_word(input longint v, inout logic sat);
        if (v > MAXV)
        begin
            sat = 1'b1;
            return MAXV;
        end
        if (v < MINV)
        begin
            sat = 1'b1;
            return MINV;
        end
        return v;
    endfunction

    // Work out the ALU result for one operation.
    function automatic alu_res_t alu_predict(input logic [3:0] kind,
                                             input logic signed [31:0] opa,
                                             input logic signed [31:0] opb);
        alu_res_t res;
        longint a;
        longint b;
        longint r;
        longint mag;
        longint num;
        longint den;
        logic sat;
        logic dz;
        logic neg;
        a = opa;
        b = opb;
        sat = 1'b0;
        dz = 1'b0;
        r = 0;
        neg = (a < 0) != (b < 0);
        case (kind)
            OP_ADD: r = clamp_word(a + b, sat);
            OP_SUB: r = clamp_word(a - b, sat);
            OP_MUL:
            begin
                // Magnitudes are at most 2^31, so the product fits 63 bits.
                mag = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + 128) >>> 8;
                r = clamp_word(neg ? -mag : mag, sat);
            end
            OP_DIV:
            begin
                if (b == 0)
                begin
                    dz = 1'b1;
                    if (a > 0)
                    begin
                        r = MAXV;
                        sat = 1'b1;
                    end
                    else if (a < 0)
                    begin
                        r = MINV;
                        sat = 1'b1;
                    end
                end
                else
                begin
                    num = (a < 0 ? -a : a) <<< 8;
                    den = b < 0 ? -b : b;
                    mag = (2 * num + den) / (2 * den);
                    r = clamp_word(neg ? -mag : mag, sat);
                end
            end
            OP_MIN: r = (a <= b) ? a : b;
            OP_MAX: r = (a > b) ? a : b;
            OP_INC: r = clamp_word(a + 1, sat);
            OP_DEC: r = clamp_word(a - 1, sat);
            OP_INT: r = a >>> 8;
            OP_FIX: r = clamp_word(a * 256, sat);
            default: r = 0;
        endcase
        res.result = r[31:0];
        res.lt = a < b;
        res.eq = a == b;
        res.gt = a > b;
        res.sat = sat;
        res.dz = dz;
        return res;
    endfunction

    // Predict on every input transfer and compare on every output transfer.
    always @(posedge clk or negedge rst_n)
    begin
        alu_res_t got;
        alu_res_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            result_count <= 0;
            expected_results.delete();
        end
        else
        begin
            if (in.valid && in.ready)
            begin
                expected_results.push_back(alu_predict(in.data[67:64], in.data[63:32],
                                                       in.data[31:0]));
            end
            if (out.valid && out.ready)
            begin
                got = out.data;
                result_count <= result_count + 1;
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("Unexpected result %h with nothing outstanding", got);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("Mismatch: result exp %h got %h, lt/eq/gt exp %b%b%b got %b%b%b, sat exp %b got %b, dz exp %b got %b",
                                     want.result, got.result, want.lt, want.eq, want.gt,
                                     got.lt, got.eq, got.gt, want.sat, got.sat,
                                     want.dz, got.dz);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    assign pending_count = expected_results.size();
endmodule
`default_nettype wire

@@ dv/fixed_point_q24_8_alu_top_test.sv @@
// Testbench top for the Q24.8 fixed-point ALU: clock, reset, stimulus and verdict.
// Depends on fpa_pkg, fpa_if, fpa_checker and the ALU RTL.
`default_nettype none
module fixed_point_q24_8_alu_top_test;
    import fpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 42;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_OPS = 1600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int fail_count;
    int pending_count;
    int result_count;
    int sent_count = 0;
    int idle_cycles = 0;
    bit long_hold = 1'b0;

    fpa_if #(.W(68)) in_ch ();
    fpa_if #(.W(37)) out_ch ();

    fixed_point_q24_8_alu_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    fpa_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in            (in_ch),
        .out           (out_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // Pick an operand biased towards the interesting corners.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'(int'($urandom_range(0, 1024)) - 512);
            4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            5: return 32'h00000100;
            default: return $urandom;
        endcase
    endfunction

    // Offer one operation, after a random gap if gaps is set, and wait for its transfer.
    task automatic send_op(input logic [3:0] kind, input logic [31:0] a,
                           input logic [31:0] b, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {kind, a, b};
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent_count++;
    endtask

    // Receiver: random stalls, one long hold-off while the pipe fills.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (long_hold)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (!out_ch.ready || out_ch.valid)
        begin
            out_ch.ready <= ($urandom_range(0, 3) == 0) ? 1'b1 : ($urandom_range(0, 1) == 1);
        end
    end

    initial
    begin
        wait (sent_count == 500);
        long_hold = 1'b1;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || long_hold)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding", pending_count);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] corners[6];
        op_t op;
        bit gaps;
        corners = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff, 32'h00000180};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed operations: every kind on corner operands, plus undefined kinds.
        op = op.first();
        for (int k = 0; k < 10; k++)
        begin
            send_op(op, corners[k % 6], corners[(k + 1) % 6], 1'b0);
            op = op.next();
        end
        send_op(OP_DIV, 32'h00000500, 32'h0, 1'b0);
        send_op(OP_DIV, 32'hfffffb00, 32'h0, 1'b0);
        send_op(OP_DIV, 32'h0, 32'h0, 1'b0);
        send_op(OP_DIV, 32'h00000001, 32'h00000002, 1'b0);
        send_op(OP_DIV, 32'hffffffff, 32'h00000002, 1'b0);
        send_op(OP_MUL, 32'h00000080, 32'h00000001, 1'b0);
        send_op(OP_MUL, 32'hffffff80, 32'h00000001, 1'b0);
        send_op(OP_INC, 32'h7fffffff, 32'h0, 1'b0);
        send_op(OP_DEC, 32'h80000000, 32'h0, 1'b0);
        send_op(OP_INT, 32'hffffff01, 32'h0, 1'b0);
        send_op(OP_FIX, 32'h00800000, 32'h0, 1'b0);
        send_op(OP_FIX, 32'hff7fffff, 32'h0, 1'b0);
        send_op(4'd12, 32'h5, 32'h3, 1'b0);
        send_op(4'd15, 32'hffffffff, 32'hffffffff, 1'b0);
        in_ch.valid <= 1'b0;

        // Sender pause until the pipe has drained.
        wait (pending_count == 0);
        @(posedge clk);

        // Random part; some stretches run back to back.
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 200 == 0)
            begin
                gaps = $urandom_range(0, 1);
            end
            send_op($urandom_range(0, 9) == 0 ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(0, 9)),
                    pick_operand(), pick_operand(), gaps);
        end
        in_ch.valid <= 1'b0;

        wait (pending_count == 0);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d operations, checked %0d results across all kinds and corners.",
                 sent_count, result_count);
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/fpa_pkg.sv
rtl/core/fpa_if.sv
rtl/core/fpa_front.sv
rtl/core/fpa_cell.sv
rtl/core/fixed_point_q24_8_alu_top.sv
dv/fpa_checker.sv
dv/fixed_point_q24_8_alu_top_test.sv
